@@ rtl/core/sha256_stream_hasher_defines.svh @@
// ----------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// shared checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define SHS_CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHS_CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// shs_pkg
// types, constants and helper functions of the sha256 stream hasher
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

   localparam logic [1:0] OP_ABSORB     = 2'd0;
   localparam logic [1:0] OP_ABSORB_FIN = 2'd1;
   localparam logic [1:0] OP_FINISH     = 2'd2;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_WB,
      ST_PMARK,
      ST_PZERO,
      ST_PLEN,
      ST_ORD,
      ST_OHOLD
   } state_type;

   // block buffer port: 16 big-endian words, byte-masked write
   typedef struct packed {
      logic        we;
      logic [3:0]  waddr;
      logic [3:0]  mask;
      logic [31:0] wdata;
      logic        re;
      logic [3:0]  raddr;
   } bb_ctl_type;

   // hash store port
   typedef struct packed {
      logic        we;
      logic [2:0]  waddr;
      logic [31:0] wdata;
      logic        re;
      logic [2:0]  raddr;
      logic        set_fresh;
      logic        clr_fresh;
   } hs_ctl_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      logic [63:0] d;
      d = {v, v} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/shs_block_buf.sv @@
// ----------------------------------------------------------------------------
// shs_block_buf
// 64-byte message block held as 16 big-endian words, byte-masked writes
// ----------------------------------------------------------------------------
`default_nettype none

module shs_block_buf (
   input  logic               clock,
   input  shs_pkg::bb_ctl_type ctl,
   output logic [31:0]        rd_q
);

   logic [31:0] mem [16];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         for (int k = 0; k < 4; k++) begin
            if (ctl.mask[k]) begin
               mem[ctl.waddr][31 - 8 * k -: 8] <= ctl.wdata[31 - 8 * k -: 8];
            end
         end
      end
      if (ctl.re) begin
         rd_q <= mem[ctl.raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/shs_hash_store.sv @@
// ----------------------------------------------------------------------------
// shs_hash_store
// eight chaining words; reads give the initial hash until the first write-back
// ----------------------------------------------------------------------------
`default_nettype none

module shs_hash_store (
   input  logic               clock,
   input  logic               reset,
   input  shs_pkg::hs_ctl_type ctl,
   output logic [31:0]        rd_val
);

   logic [31:0] mem [8];
   logic [31:0] mem_q_ff;
   logic [2:0]  ridx_ff;
   logic        fresh_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         mem_q_ff <= mem[ctl.raddr];
         ridx_ff  <= ctl.raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else if (ctl.set_fresh) begin
         fresh_ff <= 1'b1;
      end else if (ctl.clr_fresh) begin
         fresh_ff <= 1'b0;
      end
   end

   assign rd_val = fresh_ff ? shs_pkg::INIT_HASH[ridx_ff] : mem_q_ff;

endmodule

`default_nettype wire

@@ rtl/core/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-stream sha-256 with padding and eight-word digest output
// ----------------------------------------------------------------------------
//  channel   direction  ports                                     handshake
//  req       in         opcode, data_byte                         valid/stall
//  rsp       out        digest_word, word_index, last_word        valid/stall
//
//  an absorb transaction writes one byte; the 64th byte of a block starts a
//  compression: load, 64 rounds, write-back
//  one compression round per cycle sets the block time
//  a finish adds padding writes, one or two compressions, then reads out each digest word
//  synchronous reset returns to the initial hash with an empty buffer
//  req_stall is high whenever the block is busy; rsp holds while rsp_stall
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   shs_pkg::state_type state_ff, state_in;

   logic [6:0]  step_ff, step_in;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic        fin_ff, pad_ff, two_ff;
   logic        rsp_valid_ff;

   logic [31:0] r_ff [8];
   logic [31:0] wnd_ff [16];

   shs_pkg::bb_ctl_type bb_ctl;
   shs_pkg::hs_ctl_type hs_ctl;
   logic [31:0] blk_q;
   logic [31:0] hval;

   logic        req_take;
   logic        rsp_take;
   logic        absorbs;
   logic [6:0]  zero_limit;
   logic [31:0] w_new, w_t, t1, t2;
   logic [2:0]  prev_idx;
   logic [3:0]  lane_hot;

   shs_block_buf u_blk (
      .clock (clock),
      .ctl   (bb_ctl),
      .rd_q  (blk_q)
   );

   shs_hash_store u_hash (
      .clock  (clock),
      .reset  (reset),
      .ctl    (hs_ctl),
      .rd_val (hval)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign absorbs  = (req_opcode == shs_pkg::OP_ABSORB) ||
                     (req_opcode == shs_pkg::OP_ABSORB_FIN);
   // first block of a two-block padding runs zeros through the last word; else zeros stop before the length
   assign zero_limit = two_ff ? 7'd15 : 7'd13;
   assign prev_idx   = 3'(step_ff - 7'd1);
   assign lane_hot   = 4'b0001 << fill_ff[1:0];

   // message schedule and round function
   assign w_new = wnd_ff[0] + shs_pkg::small_sig0(wnd_ff[1]) + wnd_ff[9] +
                  shs_pkg::small_sig1(wnd_ff[14]);
   assign w_t   = (step_ff < 7'd16) ? blk_q : w_new;
   assign t1    = r_ff[7] + shs_pkg::big_sig1(r_ff[4]) +
                  ((r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6])) +
                  shs_pkg::ROUND_K[step_ff[5:0]] + w_t;
   assign t2    = shs_pkg::big_sig0(r_ff[0]) +
                  ((r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  shs_pkg::OP_ABSORB: begin
                     if (fill_ff == 6'd63) state_in = shs_pkg::ST_LOAD;
                  end
                  shs_pkg::OP_ABSORB_FIN: begin
                     state_in = (fill_ff == 6'd63) ? shs_pkg::ST_LOAD : shs_pkg::ST_PMARK;
                  end
                  shs_pkg::OP_FINISH: state_in = shs_pkg::ST_PMARK;
                  default: state_in = shs_pkg::ST_IDLE;
               endcase
            end
         end
         shs_pkg::ST_LOAD: begin
            if (step_ff == 7'd8) state_in = shs_pkg::ST_ROUND;
         end
         shs_pkg::ST_ROUND: begin
            if (step_ff == 7'd63) state_in = shs_pkg::ST_WB;
         end
         shs_pkg::ST_WB: begin
            if (step_ff == 7'd8) begin
               if (!fin_ff)      state_in = shs_pkg::ST_IDLE;
               else if (!pad_ff) state_in = shs_pkg::ST_PMARK;
               else if (two_ff)  state_in = shs_pkg::ST_PZERO;
               else              state_in = shs_pkg::ST_ORD;
            end
         end
         shs_pkg::ST_PMARK: state_in = shs_pkg::ST_PZERO;
         shs_pkg::ST_PZERO: begin
            if (step_ff > zero_limit) begin
               state_in = two_ff ? shs_pkg::ST_LOAD : shs_pkg::ST_PLEN;
            end
         end
         shs_pkg::ST_PLEN: begin
            if (step_ff == 7'd1) state_in = shs_pkg::ST_LOAD;
         end
         shs_pkg::ST_ORD: state_in = shs_pkg::ST_OHOLD;
         shs_pkg::ST_OHOLD: begin
            if (!rsp_stall) begin
               state_in = (step_ff[2:0] == 3'd7) ? shs_pkg::ST_IDLE : shs_pkg::ST_ORD;
            end
         end
         default: state_in = shs_pkg::ST_IDLE;
      endcase
   end

   // control outputs and memory ports
   always_comb begin
      req_stall = (state_ff != shs_pkg::ST_IDLE);
      bb_ctl    = '0;
      hs_ctl    = '0;
      step_in   = (state_in != state_ff) ? 7'd0 : step_ff + 7'd1;
      case (state_ff)
         shs_pkg::ST_IDLE: begin
            step_in = 7'd0;
            if (req_valid && absorbs) begin
               bb_ctl.we    = 1'b1;
               bb_ctl.waddr = fill_ff[5:2];
               bb_ctl.mask  = lane_hot;
               bb_ctl.wdata = {4{req_data_byte}};
            end
         end
         shs_pkg::ST_LOAD: begin
            hs_ctl.re    = (step_ff < 7'd8);
            hs_ctl.raddr = step_ff[2:0];
            // first schedule word ready for round zero
            bb_ctl.re    = (step_ff == 7'd8);
            bb_ctl.raddr = 4'd0;
         end
         shs_pkg::ST_ROUND: begin
            bb_ctl.re    = 1'b1;
            bb_ctl.raddr = 4'(step_ff + 7'd1);
         end
         shs_pkg::ST_WB: begin
            hs_ctl.re        = (step_ff < 7'd8);
            hs_ctl.raddr     = step_ff[2:0];
            hs_ctl.we        = (step_ff != 7'd0);
            hs_ctl.waddr     = prev_idx;
            hs_ctl.wdata     = hval + r_ff[prev_idx];
            hs_ctl.clr_fresh = (step_ff == 7'd8);
         end
         shs_pkg::ST_PMARK: begin
            // 0x80 at the fill position, zeros after it in the same word
            bb_ctl.we    = 1'b1;
            bb_ctl.waddr = fill_ff[5:2];
            bb_ctl.mask  = ~(lane_hot - 4'd1);
            for (int k = 0; k < 4; k++) begin
               bb_ctl.wdata[31 - 8 * k -: 8] =
                  lane_hot[k] ? shs_pkg::PAD_MARK_BYTE : 8'd0;
            end
            step_in = {3'd0, fill_ff[5:2]} + 7'd1;
         end
         shs_pkg::ST_PZERO: begin
            bb_ctl.we    = (step_ff <= zero_limit);
            bb_ctl.waddr = step_ff[3:0];
            bb_ctl.mask  = 4'hf;
            bb_ctl.wdata = '0;
         end
         shs_pkg::ST_PLEN: begin
            bb_ctl.we    = 1'b1;
            bb_ctl.waddr = step_ff[0] ? 4'd15 : 4'd14;
            bb_ctl.mask  = 4'hf;
            bb_ctl.wdata = step_ff[0] ? bits_ff[31:0] : bits_ff[63:32];
         end
         shs_pkg::ST_ORD: begin
            hs_ctl.re    = 1'b1;
            hs_ctl.raddr = step_ff[2:0];
            step_in      = step_ff;
         end
         shs_pkg::ST_OHOLD: begin
            if (!rsp_stall) begin
               step_in          = (step_ff[2:0] == 3'd7) ? 7'd0 : step_ff + 7'd1;
               hs_ctl.set_fresh = (step_ff[2:0] == 3'd7);
            end else begin
               step_in = step_ff;
            end
         end
         default: step_in = 7'd0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shs_pkg::ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         bits_ff      <= '0;
         fin_ff       <= 1'b0;
         pad_ff       <= 1'b0;
         two_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= (state_in == shs_pkg::ST_OHOLD);
         if (req_take && absorbs) begin
            fill_ff <= fill_ff + 6'd1;
            bits_ff <= bits_ff + 64'd8;
         end
         if (req_take && (req_opcode == shs_pkg::OP_ABSORB_FIN ||
                          req_opcode == shs_pkg::OP_FINISH)) begin
            fin_ff <= 1'b1;
         end
         if (state_ff == shs_pkg::ST_PMARK) begin
            pad_ff <= 1'b1;
            two_ff <= (fill_ff >= 6'd56);
         end
         if (state_ff == shs_pkg::ST_WB && state_in == shs_pkg::ST_PZERO) begin
            two_ff <= 1'b0;
         end
         // digest delivered: start the next message
         if (rsp_take && step_ff[2:0] == 3'd7) begin
            fin_ff  <= 1'b0;
            pad_ff  <= 1'b0;
            fill_ff <= '0;
            bits_ff <= '0;
         end
      end
   end

   // working variables and schedule window
   always_ff @(posedge clock) begin
      if (state_ff == shs_pkg::ST_LOAD && step_ff != 7'd0) begin
         r_ff[prev_idx] <= hval;
      end
      if (state_ff == shs_pkg::ST_ROUND) begin
         r_ff[7] <= r_ff[6];
         r_ff[6] <= r_ff[5];
         r_ff[5] <= r_ff[4];
         r_ff[4] <= r_ff[3] + t1;
         r_ff[3] <= r_ff[2];
         r_ff[2] <= r_ff[1];
         r_ff[1] <= r_ff[0];
         r_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) begin
            wnd_ff[i] <= wnd_ff[i + 1];
         end
         wnd_ff[15] <= w_t;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = hval;
   assign rsp_word_index  = step_ff[2:0];
   assign rsp_last_word   = (step_ff[2:0] == 3'd7);

   `SHS_CHK_SAME(a_rsp_only_out, clock, reset, rsp_valid_ff, state_ff == shs_pkg::ST_OHOLD, "rsp valid outside output phase")
   `SHS_CHK_NEXT(a_full_block_loads, clock, reset, req_take && req_opcode == shs_pkg::OP_ABSORB && fill_ff == 6'd63, state_ff == shs_pkg::ST_LOAD, "full block did not start compression")
   `SHS_CHK_NEXT(a_last_word_ends, clock, reset, rsp_take && rsp_last_word, !rsp_valid_ff && fill_ff == 6'd0, "digest end did not restart message")
   `SHS_CHK_NEXT(a_rounds_to_wb, clock, reset, state_ff == shs_pkg::ST_ROUND && step_ff == 7'd63, state_ff == shs_pkg::ST_WB, "round count overrun")

endmodule

`default_nettype wire
